/* src/stb_pkg.sv */
// ----------------------------------------------------------------------------
// stb_pkg: shared types and constants for the software timer bank
// Operation codes, configuration register indexes, field widths and the
// command struct passed from the top level to the datapath units.
// ----------------------------------------------------------------------------
package stb_pkg;

    localparam int NUM_TIMERS = 8;

    localparam int OP_W     = 2;
    localparam int IDX_W    = 3;
    localparam int TICKS_W  = 16;
    localparam int MASK_W   = 8;
    localparam int STEP_W   = 16;
    localparam int FRAC_W   = 30;
    localparam int ACC_W    = 32;
    localparam int CMP_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 30;

    typedef enum logic [OP_W-1:0] {
        OP_TICK = 2'd0,
        OP_SET  = 2'd1,
        OP_POLL = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ONESHOT_MASK = 2'd0,
        CFG_COMPARE_STEP = 2'd1,
        CFG_FRACTION_ADD = 2'd2,
        CFG_FRACTION_MOD = 2'd3
    } cfg_idx_t;

    // One decoded operation, strobes already qualified by the input beat
    typedef struct packed {
        logic               tick;
        logic               load;
        logic               poll;
        logic [IDX_W-1:0]   idx;
        logic [TICKS_W-1:0] ticks;
    } cmd_t;

endpackage

/* src/stb_timers.sv */
// ----------------------------------------------------------------------------
// stb_timers: countdown timer array with expiry flags and idle status
// Applies tick, set_time and poll to every timer in parallel and returns
// the poll flag and the idle status (a tick sets it when no timer was running).
// ----------------------------------------------------------------------------
module stb_timers
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  stb_pkg::cmd_t               cmd,
    input  logic [stb_pkg::MASK_W-1:0]  oneshot_mask,
    output logic                        flag,
    output logic                        idle_next
);

    logic [stb_pkg::TICKS_W-1:0] count_reg  [stb_pkg::NUM_TIMERS];
    logic [stb_pkg::TICKS_W-1:0] count_next [stb_pkg::NUM_TIMERS];
    logic [stb_pkg::TICKS_W-1:0] reload_reg  [stb_pkg::NUM_TIMERS];
    logic [stb_pkg::TICKS_W-1:0] reload_next [stb_pkg::NUM_TIMERS];
    logic [stb_pkg::NUM_TIMERS-1:0] expired_reg, expired_next;
    logic                           idle_reg;
    logic [stb_pkg::NUM_TIMERS-1:0] sel, oneshot, running, rearm;

    always_comb
    begin
        for (int t = 0; t < stb_pkg::NUM_TIMERS; t++)
        begin
            sel[t]     = (t < (1 << stb_pkg::IDX_W)) &&
                         (cmd.idx == stb_pkg::IDX_W'(t));
            oneshot[t] = (t < stb_pkg::MASK_W) && oneshot_mask[t % stb_pkg::MASK_W];
            running[t] = (count_reg[t] != '0);
            rearm[t]   = cmd.poll && sel[t] && expired_reg[t] && !oneshot[t];
        end
    end

    always_comb
    begin
        flag      = cmd.poll && ((sel & expired_reg) != '0);
        idle_next = idle_reg;
        for (int t = 0; t < stb_pkg::NUM_TIMERS; t++)
        begin
            count_next[t]   = count_reg[t];
            reload_next[t]  = reload_reg[t];
            expired_next[t] = expired_reg[t];
            if (cmd.tick && running[t])
            begin
                count_next[t] = count_reg[t] - stb_pkg::TICKS_W'(1);
                if (count_reg[t] == stb_pkg::TICKS_W'(1))
                    expired_next[t] = 1'b1;
            end
            if (cmd.load && sel[t])
            begin
                count_next[t]   = cmd.ticks;
                reload_next[t]  = cmd.ticks;
                expired_next[t] = 1'b0;
                if (cmd.ticks != '0)
                    idle_next = 1'b0;
            end
            if (cmd.poll && sel[t])
                expired_next[t] = 1'b0;
            if (rearm[t])
            begin
                count_next[t] = reload_reg[t];
                if (reload_reg[t] != '0)
                    idle_next = 1'b0;
            end
        end
        if (cmd.tick)
            idle_next = (running == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < stb_pkg::NUM_TIMERS; t++)
            begin
                count_reg[t]  <= '0;
                reload_reg[t] <= '0;
            end
            expired_reg <= '0;
            idle_reg    <= 1'b1;
        end
        else
        begin
            count_reg   <= count_next;
            reload_reg  <= reload_next;
            expired_reg <= expired_next;
            idle_reg    <= idle_next;
        end
    end

endmodule

/* src/stb_compare.sv */
// ----------------------------------------------------------------------------
// stb_compare: drift-compensated output compare value
// Advances the compare value by the step on each tick, plus one when the
// fractional accumulator rises above half the modulus.
// ----------------------------------------------------------------------------
module stb_compare
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        tick,
    input  logic [stb_pkg::STEP_W-1:0]  compare_step,
    input  logic [stb_pkg::FRAC_W-1:0]  fraction_add,
    input  logic [stb_pkg::FRAC_W-1:0]  fraction_modulus,
    output logic [stb_pkg::CMP_W-1:0]   compare_next
);

    logic [stb_pkg::CMP_W-1:0] compare_reg;
    logic [stb_pkg::ACC_W-1:0] drift_acc_reg, drift_acc_next;
    logic [stb_pkg::ACC_W-1:0] acc_sum, half;
    logic                      carry;

    always_comb
    begin
        acc_sum = drift_acc_reg + stb_pkg::ACC_W'(fraction_add);
        half    = stb_pkg::ACC_W'(fraction_modulus >> 1);
        carry   = $signed(acc_sum) > $signed(half);
        drift_acc_next = drift_acc_reg;
        compare_next   = compare_reg;
        if (tick)
        begin
            drift_acc_next = carry ? acc_sum - stb_pkg::ACC_W'(fraction_modulus) : acc_sum;
            compare_next   = compare_reg + stb_pkg::CMP_W'(compare_step)
                           + stb_pkg::CMP_W'(carry);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compare_reg   <= '0;
            drift_acc_reg <= '0;
        end
        else
        begin
            compare_reg   <= compare_next;
            drift_acc_reg <= drift_acc_next;
        end
    end

endmodule

/* src/software_timer_bank_top.sv */
// ----------------------------------------------------------------------------
// software_timer_bank_top: bank of countdown timers with compare generator
// The result is registered and appears in the cycle after the beat is accepted.
// Throughput: one item per cycle unless out_ready is low; all timers update in parallel in one pass.
// The result register frees as it is taken, so a new beat is accepted in the
// same cycle the previous result leaves.
// Reset: counts, reloads and expiry flags clear, idle set, compare and drift zero,
// configuration back to its defaults (modulus one).
// ----------------------------------------------------------------------------
module software_timer_bank_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [stb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [stb_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [stb_pkg::OP_W-1:0]            operation,
    input  logic [stb_pkg::IDX_W-1:0]           timer_index,
    input  logic [stb_pkg::TICKS_W-1:0]         ticks,
    // result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                flagged,
    output logic                                all_idle,
    output logic [stb_pkg::CMP_W-1:0]           compare_value
);

    // Configuration registers
    logic [stb_pkg::MASK_W-1:0] oneshot_mask_reg;
    logic [stb_pkg::STEP_W-1:0] compare_step_reg;
    logic [stb_pkg::FRAC_W-1:0] fraction_add_reg;
    logic [stb_pkg::FRAC_W-1:0] fraction_mod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oneshot_mask_reg <= '0;
            compare_step_reg <= '0;
            fraction_add_reg <= '0;
            fraction_mod_reg <= stb_pkg::FRAC_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (stb_pkg::cfg_idx_t'(cfg_index))
                stb_pkg::CFG_ONESHOT_MASK: oneshot_mask_reg <= cfg_wdata[stb_pkg::MASK_W-1:0];
                stb_pkg::CFG_COMPARE_STEP: compare_step_reg <= cfg_wdata[stb_pkg::STEP_W-1:0];
                stb_pkg::CFG_FRACTION_ADD: fraction_add_reg <= cfg_wdata;
                stb_pkg::CFG_FRACTION_MOD: fraction_mod_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Accept a beat whenever the result register is empty or being drained
    logic           accept;
    stb_pkg::cmd_t  cmd;

    assign in_ready = !out_valid || out_ready;
    assign accept   = in_valid && in_ready;

    // Decode the operation; the unused code leaves every strobe low
    always_comb
    begin
        cmd       = '0;
        cmd.idx   = timer_index;
        cmd.ticks = ticks;
        if (accept)
        begin
            unique case (stb_pkg::op_t'(operation))
                stb_pkg::OP_TICK: cmd.tick = 1'b1;
                stb_pkg::OP_SET:  cmd.load = 1'b1;
                stb_pkg::OP_POLL: cmd.poll = 1'b1;
                default: ;
            endcase
        end
    end

    logic                      flag;
    logic                      idle_next;
    logic [stb_pkg::CMP_W-1:0] compare_next;

    stb_timers u_timers
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .oneshot_mask (oneshot_mask_reg),
        .flag         (flag),
        .idle_next    (idle_next)
    );

    stb_compare u_compare
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .tick             (cmd.tick),
        .compare_step     (compare_step_reg),
        .fraction_add     (fraction_add_reg),
        .fraction_modulus (fraction_mod_reg),
        .compare_next     (compare_next)
    );

    // Result register: hold the beat until the consumer takes it
    logic                      out_valid_reg;
    logic                      flagged_reg;
    logic                      all_idle_reg;
    logic [stb_pkg::CMP_W-1:0] compare_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            flagged_reg       <= flag;
            all_idle_reg      <= idle_next;
            compare_value_reg <= compare_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign flagged       = flagged_reg;
    assign all_idle      = all_idle_reg;
    assign compare_value = compare_value_reg;

endmodule
